// ===== sv/ldpf_pkg.sv =====
// Shared types and constants for the Langevin Drude pair force block.
// Depends on nothing; the top level and the testbench import it.
`default_nettype none
package ldpf_pkg;

  localparam int QW    = 32;
  localparam int NSW   = 16;
  localparam int WW    = 17;
  localparam int MTW   = QW + 1;
  localparam int SQW   = 24;
  localparam int FW    = 52;
  localparam int CFG_W = 3;

  localparam logic [CFG_W-1:0] CFG_CORE_PERIOD  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_DRUDE_PERIOD = 3'd1;
  localparam logic [CFG_W-1:0] CFG_CORE_TEMP    = 3'd2;
  localparam logic [CFG_W-1:0] CFG_DRUDE_TEMP   = 3'd3;
  localparam logic [CFG_W-1:0] CFG_BOLTZMANN    = 3'd4;
  localparam logic [CFG_W-1:0] CFG_TIME_STEP    = 3'd5;
  localparam logic [CFG_W-1:0] CFG_FORCE_ACCEL  = 3'd6;
  localparam logic [CFG_W-1:0] CFG_MV2_ENERGY   = 3'd7;

  localparam logic [QW-1:0] RST_CORE_PERIOD  = 32'd6553600;
  localparam logic [QW-1:0] RST_DRUDE_PERIOD = 32'd65536;
  localparam logic [QW-1:0] RST_TEMP         = 32'd0;
  localparam logic [QW-1:0] RST_UNIT         = 32'd65536;

  localparam logic [QW-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic                  mode;
    logic [QW-1:0]         core_mass;
    logic [QW-1:0]         drude_mass;
    logic signed [QW-1:0]  core_velocity;
    logic signed [QW-1:0]  drude_velocity;
    logic signed [NSW-1:0] core_noise;
    logic signed [NSW-1:0] drude_noise;
  } in_t;

  typedef struct packed {
    logic signed [QW-1:0] core_force_add;
    logic signed [QW-1:0] drude_force_add;
  } out_t;

  typedef struct packed {
    logic                  mode;
    logic signed [QW-1:0]  vc;
    logic signed [QW-1:0]  vd;
    logic signed [NSW-1:0] nc;
    logic signed [NSW-1:0] nd;
  } kin_t;

endpackage
`default_nettype wire

// ===== sv/ldpf_div.sv =====
// Pipelined radix-2 restoring divider, one quotient bit per stage, several lanes.
// A sideband word travels with each word. Depends on no package.
`default_nettype none
module ldpf_div #(
  parameter int NL = 2,
  parameter int DW = 32,
  parameter int QB = 32,
  parameter int SW = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [NL-1:0][DW-1:0]  in_rem,
  input  wire logic [NL-1:0][QB-1:0]  in_lo,
  input  wire logic [NL-1:0][DW-1:0]  in_den,
  input  wire logic [SW-1:0]          in_side,
  output logic                        out_valid,
  output logic [NL-1:0][QB-1:0]       out_q,
  output logic [SW-1:0]               out_side
);

  logic                      v_r    [QB];
  logic [NL-1:0][QB-1:0]     lq_r   [QB];
  logic [SW-1:0]             side_r [QB];
  logic [NL-1:0][DW-1:0]     rem_r  [QB-1];
  logic [NL-1:0][DW-1:0]     den_r  [QB-1];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic                  pv;
    logic [NL-1:0][DW-1:0] prem;
    logic [NL-1:0][DW-1:0] pden;
    logic [NL-1:0][QB-1:0] plq;
    logic [SW-1:0]         pside;
    logic [NL-1:0][DW-1:0] rem_nxt;
    logic [NL-1:0][QB-1:0] lq_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_rem;
      assign pden  = in_den;
      assign plq   = in_lo;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign pden  = den_r[k-1];
      assign plq   = lq_r[k-1];
      assign pside = side_r[k-1];
    end

    always_comb begin
      logic [DW:0] t;
      t = '0;
      for (int l = 0; l < NL; l++) begin
        t = {prem[l], plq[l][QB-1]};
        if (t >= {1'b0, pden[l]}) begin
          rem_nxt[l] = DW'(t - {1'b0, pden[l]});
          lq_nxt[l]  = {plq[l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[l] = t[DW-1:0];
          lq_nxt[l]  = {plq[l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lq_r[k]   <= lq_nxt;
        side_r[k] <= pside;
      end
    end

    if (k < QB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= pden;
        end
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_q     = lq_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule
`default_nettype wire

// ===== sv/ldpf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, several lanes.
// A sideband word travels with each word. Depends on no package.
`default_nettype none
module ldpf_sqrt #(
  parameter int NL = 2,
  parameter int RW = 24,
  parameter int SW = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [NL-1:0][2*RW-1:0] in_x,
  input  wire logic [SW-1:0]           in_side,
  output logic                         out_valid,
  output logic [NL-1:0][RW-1:0]        out_root,
  output logic [SW-1:0]                out_side
);

  logic                      v_r    [RW];
  logic [NL-1:0][RW-1:0]     root_r [RW];
  logic [SW-1:0]             side_r [RW];
  logic [NL-1:0][RW+1:0]     rem_r  [RW-1];
  logic [NL-1:0][2*RW-1:0]   x_r    [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic                    pv;
    logic [NL-1:0][RW+1:0]   prem;
    logic [NL-1:0][RW-1:0]   proot;
    logic [NL-1:0][2*RW-1:0] px;
    logic [SW-1:0]           pside;
    logic [NL-1:0][RW+1:0]   rem_nxt;
    logic [NL-1:0][RW-1:0]   root_nxt;
    logic [NL-1:0][2*RW-1:0] x_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign px    = in_x;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign px    = x_r[k-1];
      assign pside = side_r[k-1];
    end

    always_comb begin
      logic [RW+3:0] t;
      logic [RW+3:0] trial;
      t     = '0;
      trial = '0;
      for (int l = 0; l < NL; l++) begin
        t        = {prem[l], px[l][2*RW-1 -: 2]};
        trial    = {2'b00, proot[l], 2'b01};
        x_nxt[l] = {px[l][2*RW-3:0], 2'b00};
        if (t >= trial) begin
          rem_nxt[l]  = (RW+2)'(t - trial);
          root_nxt[l] = {proot[l][RW-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = t[RW+1:0];
          root_nxt[l] = {proot[l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_nxt;
        side_r[k] <= pside;
      end
    end

    if (k < RW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          x_r[k]   <= x_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule
`default_nettype wire

// ===== sv/langevin_drude_pair_force.sv =====
// Top level: Langevin friction and noise force for an atom or a core-Drude pair.
// One word per cycle while no skid word is held; in_ready is low while one is.
// The pipeline holds six 32-stage radix-2 dividers and a 24-stage root in series.
// Reset clears all valid bits and loads the register defaults; payload is not reset.
// Depends on ldpf_pkg, ldpf_div and ldpf_sqrt.
`default_nettype none
module langevin_drude_pair_force (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ldpf_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ldpf_pkg::out_t                    out_data,
  input  wire logic                         cfg_we,
  input  wire logic [ldpf_pkg::CFG_W-1:0]   cfg_index,
  input  wire logic [ldpf_pkg::QW-1:0]      cfg_wdata
);
  import ldpf_pkg::*;

  typedef struct packed {
    kin_t          k;
    logic          mt_zero;
    logic [QW-1:0] ma;
  } d1s_t;

  typedef struct packed {
    kin_t          k;
    logic [WW-1:0] wc;
    logic [WW-1:0] wd;
  } ph_t;

  typedef struct packed {
    ph_t        p;
    logic [1:0] sat;
  } dsa_t;

  typedef struct packed {
    ph_t                 p;
    logic [1:0][QW-1:0]  g;
  } sq_t;

  typedef struct packed {
    ph_t                 p;
    logic [1:0][QW-1:0]  g;
    logic [1:0]          sat;
  } dsb_t;

  function automatic logic [QW-1:0] qrem(input logic [QW-1:0] a);
    return {16'h0, a[QW-1:16]};
  endfunction

  function automatic logic [QW-1:0] qlo(input logic [QW-1:0] a);
    return {a[15:0], 16'h0};
  endfunction

  function automatic logic qsat(input logic [QW-1:0] a, input logic [QW-1:0] b);
    return {16'h0, a[QW-1:16]} >= b;
  endfunction

  function automatic logic [QW-1:0] qmsat(input logic [2*QW-1:0] p);
    return (p[2*QW-1:48] != '0) ? '1 : p[47:16];
  endfunction

  function automatic logic signed [FW-1:0] wmul(input logic [WW-1:0] w,
                                                input logic signed [FW-1:0] b);
    logic                neg;
    logic [FW-1:0]       mag;
    logic [FW+WW-1:0]    pr;
    logic [FW-1:0]       r;
    neg = b[FW-1];
    mag = neg ? FW'(-b) : FW'(b);
    pr  = (FW+WW)'(mag) * (FW+WW)'(w);
    r   = pr[FW+15:16];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [FW-1:0] smul_v(input logic [QW-1:0] g,
                                                  input logic signed [33:0] v);
    logic          neg;
    logic [33:0]   mag;
    logic [65:0]   pr;
    logic [49:0]   r;
    neg = v[33];
    mag = neg ? 34'(-v) : 34'(v);
    pr  = 66'(mag) * 66'(g);
    r   = pr[65:16];
    return neg ? -$signed(FW'(r)) : $signed(FW'(r));
  endfunction

  function automatic logic signed [FW-1:0] smul_n(input logic [SQW-1:0] c,
                                                  input logic signed [NSW-1:0] n);
    logic          neg;
    logic [NSW-1:0] mag;
    logic [39:0]   pr;
    logic [27:0]   r;
    neg = n[NSW-1];
    mag = neg ? NSW'(-n) : NSW'(n);
    pr  = 40'(mag) * 40'(c);
    r   = pr[39:12];
    return neg ? -$signed(FW'(r)) : $signed(FW'(r));
  endfunction

  function automatic logic [QW-1:0] sat32(input logic signed [FW-1:0] x);
    if (x[FW-1:31] == '0 || x[FW-1:31] == '1) begin
      return x[QW-1:0];
    end
    return x[FW-1] ? S32_MIN : S32_MAX;
  endfunction

  // Configuration registers.
  logic [QW-1:0] core_period_r, drude_period_r, core_temp_r, drude_temp_r;
  logic [QW-1:0] kb_r, time_step_r, fta_r, mv2e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_period_r  <= RST_CORE_PERIOD;
      drude_period_r <= RST_DRUDE_PERIOD;
      core_temp_r    <= RST_TEMP;
      drude_temp_r   <= RST_TEMP;
      kb_r           <= RST_UNIT;
      time_step_r    <= RST_UNIT;
      fta_r          <= RST_UNIT;
      mv2e_r         <= RST_UNIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORE_PERIOD:  core_period_r  <= cfg_wdata;
        CFG_DRUDE_PERIOD: drude_period_r <= cfg_wdata;
        CFG_CORE_TEMP:    core_temp_r    <= cfg_wdata;
        CFG_DRUDE_TEMP:   drude_temp_r   <= cfg_wdata;
        CFG_BOLTZMANN:    kb_r           <= cfg_wdata;
        CFG_TIME_STEP:    time_step_r    <= cfg_wdata;
        CFG_FORCE_ACCEL:  fta_r          <= cfg_wdata;
        CFG_MV2_ENERGY:   mv2e_r         <= cfg_wdata;
      endcase
    end
  end

  // Pipeline advance and output skid.
  logic   en;
  logic   skid_v_r, out_v_r;
  out_t   skid_d_r, out_d_r;
  logic   e5_v_r;
  out_t   e5_d_r;
  logic   leaving;

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign leaving  = e5_v_r && en;

  // Stage 1: total mass and mass product.
  logic             s1_v_r;
  d1s_t             s1_s_r;
  logic [QW-1:0]    s1_mc_r, s1_md_r;
  logic [MTW-1:0]   s1_mt_r;
  logic [2*QW-1:0]  s1_prod_r;
  logic [MTW-1:0]   mt_nxt;

  assign mt_nxt = {1'b0, in_data.core_mass} + {1'b0, in_data.drude_mass};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r.k.mode  <= in_data.mode;
      s1_s_r.k.vc    <= in_data.core_velocity;
      s1_s_r.k.vd    <= in_data.drude_velocity;
      s1_s_r.k.nc    <= in_data.core_noise;
      s1_s_r.k.nd    <= in_data.drude_noise;
      s1_s_r.mt_zero <= (mt_nxt == '0);
      s1_s_r.ma      <= !in_data.mode ? in_data.core_mass :
                        (mt_nxt[QW] ? '1 : mt_nxt[QW-1:0]);
      s1_mc_r        <= in_data.core_mass;
      s1_md_r        <= in_data.drude_mass;
      s1_mt_r        <= mt_nxt;
      s1_prod_r      <= in_data.core_mass * in_data.drude_mass;
    end
  end

  // Reduced mass and the two weights, all divided by the total mass.
  logic [2:0][MTW-1:0] d1_rem, d1_den;
  logic [2:0][QW-1:0]  d1_lo, d1_q;
  logic                d1_v;
  d1s_t                d1_s;

  always_comb begin
    d1_rem[0] = {1'b0, s1_prod_r[2*QW-1:QW]};
    d1_rem[1] = {17'h0, s1_mc_r[QW-1:16]};
    d1_rem[2] = {17'h0, s1_md_r[QW-1:16]};
    d1_lo[0]  = s1_prod_r[QW-1:0];
    d1_lo[1]  = {s1_mc_r[15:0], 16'h0};
    d1_lo[2]  = {s1_md_r[15:0], 16'h0};
    d1_den    = {3{s1_mt_r}};
  end

  ldpf_div #(.NL(3), .DW(MTW), .QB(QW), .SW($bits(d1s_t))) u_div_mass (
    .clk, .rst_n, .en,
    .in_valid(s1_v_r), .in_rem(d1_rem), .in_lo(d1_lo), .in_den(d1_den), .in_side(s1_s_r),
    .out_valid(d1_v), .out_q(d1_q), .out_side(d1_s)
  );

  // Friction chain: mass / period, then / force_to_accel.
  logic [1:0][QW-1:0] d2_a, d2_rem, d2_lo, d2_den, d2_q;
  dsa_t               d2_si, d2_so;
  logic               d2_v;

  always_comb begin
    d2_si.p.k  = d1_s.k;
    d2_si.p.wc = d1_s.mt_zero ? '0 : d1_q[1][WW-1:0];
    d2_si.p.wd = d1_s.mt_zero ? '0 : d1_q[2][WW-1:0];
    d2_a[0]    = d1_s.ma;
    d2_a[1]    = d1_s.mt_zero ? '0 : d1_q[0];
    d2_den[0]  = core_period_r;
    d2_den[1]  = drude_period_r;
    for (int l = 0; l < 2; l++) begin
      d2_rem[l]    = qrem(d2_a[l]);
      d2_lo[l]     = qlo(d2_a[l]);
      d2_si.sat[l] = qsat(d2_a[l], d2_den[l]);
    end
  end

  ldpf_div #(.NL(2), .DW(QW), .QB(QW), .SW($bits(dsa_t))) u_div_period (
    .clk, .rst_n, .en,
    .in_valid(d1_v), .in_rem(d2_rem), .in_lo(d2_lo), .in_den(d2_den), .in_side(d2_si),
    .out_valid(d2_v), .out_q(d2_q), .out_side(d2_so)
  );

  logic [1:0][QW-1:0] d3_a, d3_rem, d3_lo, d3_den, d3_q;
  dsa_t               d3_si, d3_so;
  logic               d3_v;

  always_comb begin
    d3_si.p = d2_so.p;
    for (int l = 0; l < 2; l++) begin
      d3_a[l]      = d2_so.sat[l] ? '1 : d2_q[l];
      d3_den[l]    = fta_r;
      d3_rem[l]    = qrem(d3_a[l]);
      d3_lo[l]     = qlo(d3_a[l]);
      d3_si.sat[l] = qsat(d3_a[l], fta_r);
    end
  end

  ldpf_div #(.NL(2), .DW(QW), .QB(QW), .SW($bits(dsa_t))) u_div_drag (
    .clk, .rst_n, .en,
    .in_valid(d2_v), .in_rem(d3_rem), .in_lo(d3_lo), .in_den(d3_den), .in_side(d3_si),
    .out_valid(d3_v), .out_q(d3_q), .out_side(d3_so)
  );

  // Noise variance: 2*G*kb*T.
  logic                 m1_v_r, m2_v_r;
  sq_t                  m1_s_r, m2_s_r;
  logic [1:0][2*QW-1:0] m1_p_r, m2_p_r;
  logic [1:0][QW-1:0]   g_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      g_nxt[l] = d3_so.sat[l] ? '1 : d3_q[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= d3_v;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_s_r.p <= d3_so.p;
      m1_s_r.g <= g_nxt;
      m2_s_r   <= m1_s_r;
      for (int l = 0; l < 2; l++) begin
        m1_p_r[l] <= (g_nxt[l][QW-1] ? {QW{1'b1}} : {g_nxt[l][QW-2:0], 1'b0}) * kb_r;
      end
      m2_p_r[0] <= qmsat(m1_p_r[0]) * core_temp_r;
      m2_p_r[1] <= qmsat(m1_p_r[1]) * drude_temp_r;
    end
  end

  // Division by time_step, force_to_accel and mv2_to_energy.
  logic [1:0][QW-1:0] d4_a, d4_rem, d4_lo, d4_den, d4_q;
  dsb_t               d4_si, d4_so;
  logic               d4_v;

  always_comb begin
    d4_si.p = m2_s_r.p;
    d4_si.g = m2_s_r.g;
    for (int l = 0; l < 2; l++) begin
      d4_a[l]      = qmsat(m2_p_r[l]);
      d4_den[l]    = time_step_r;
      d4_rem[l]    = qrem(d4_a[l]);
      d4_lo[l]     = qlo(d4_a[l]);
      d4_si.sat[l] = qsat(d4_a[l], time_step_r);
    end
  end

  ldpf_div #(.NL(2), .DW(QW), .QB(QW), .SW($bits(dsb_t))) u_div_step (
    .clk, .rst_n, .en,
    .in_valid(m2_v_r), .in_rem(d4_rem), .in_lo(d4_lo), .in_den(d4_den), .in_side(d4_si),
    .out_valid(d4_v), .out_q(d4_q), .out_side(d4_so)
  );

  logic [1:0][QW-1:0] d5_a, d5_rem, d5_lo, d5_den, d5_q;
  dsb_t               d5_si, d5_so;
  logic               d5_v;

  always_comb begin
    d5_si.p = d4_so.p;
    d5_si.g = d4_so.g;
    for (int l = 0; l < 2; l++) begin
      d5_a[l]      = d4_so.sat[l] ? '1 : d4_q[l];
      d5_den[l]    = fta_r;
      d5_rem[l]    = qrem(d5_a[l]);
      d5_lo[l]     = qlo(d5_a[l]);
      d5_si.sat[l] = qsat(d5_a[l], fta_r);
    end
  end

  ldpf_div #(.NL(2), .DW(QW), .QB(QW), .SW($bits(dsb_t))) u_div_accel (
    .clk, .rst_n, .en,
    .in_valid(d4_v), .in_rem(d5_rem), .in_lo(d5_lo), .in_den(d5_den), .in_side(d5_si),
    .out_valid(d5_v), .out_q(d5_q), .out_side(d5_so)
  );

  logic [1:0][QW-1:0] d6_a, d6_rem, d6_lo, d6_den, d6_q;
  dsb_t               d6_si, d6_so;
  logic               d6_v;

  always_comb begin
    d6_si.p = d5_so.p;
    d6_si.g = d5_so.g;
    for (int l = 0; l < 2; l++) begin
      d6_a[l]      = d5_so.sat[l] ? '1 : d5_q[l];
      d6_den[l]    = mv2e_r;
      d6_rem[l]    = qrem(d6_a[l]);
      d6_lo[l]     = qlo(d6_a[l]);
      d6_si.sat[l] = qsat(d6_a[l], mv2e_r);
    end
  end

  ldpf_div #(.NL(2), .DW(QW), .QB(QW), .SW($bits(dsb_t))) u_div_energy (
    .clk, .rst_n, .en,
    .in_valid(d5_v), .in_rem(d6_rem), .in_lo(d6_lo), .in_den(d6_den), .in_side(d6_si),
    .out_valid(d6_v), .out_q(d6_q), .out_side(d6_so)
  );

  // Noise amplitude as the square root of the variance.
  logic [1:0][2*SQW-1:0] sq_x;
  logic [1:0][SQW-1:0]   sq_c;
  sq_t                   sq_si, sq_so;
  logic                  sq_v;

  always_comb begin
    sq_si.p = d6_so.p;
    sq_si.g = d6_so.g;
    for (int l = 0; l < 2; l++) begin
      sq_x[l] = {(d6_so.sat[l] ? {QW{1'b1}} : d6_q[l]), 16'h0};
    end
  end

  ldpf_sqrt #(.NL(2), .RW(SQW), .SW($bits(sq_t))) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(d6_v), .in_x(sq_x), .in_side(sq_si),
    .out_valid(sq_v), .out_root(sq_c), .out_side(sq_so)
  );

  // Force stages.
  logic                      e1_v_r, e2_v_r, e3_v_r, e4_v_r;
  kin_t                      e1_k_r;
  logic [WW-1:0]             e1_wc_r, e1_wd_r, e2_wc_r, e2_wd_r, e3_wc_r, e3_wd_r;
  logic [1:0][QW-1:0]        e1_g_r;
  logic [1:0][SQW-1:0]       e1_c_r;
  logic signed [33:0]        e1_va_r, e1_vb_r;
  logic                      e2_mode_r, e3_mode_r, e4_mode_r;
  logic signed [FW-1:0]      e2_pc_r [2];
  logic signed [FW-1:0]      e2_pg_r [2];
  logic signed [FW-1:0]      e3_f_r  [2];
  logic signed [FW-1:0]      e4_wa_r, e4_wb_r, e4_fa_r, e4_fb_r;
  logic signed [FW-1:0]      vcm;
  logic signed [FW-1:0]      fc, fd;

  assign vcm = wmul(sq_so.p.wc, FW'(sq_so.p.k.vc)) + wmul(sq_so.p.wd, FW'(sq_so.p.k.vd));

  always_comb begin
    if (e4_mode_r) begin
      fc = e4_wa_r - e4_fb_r;
      fd = e4_wb_r + e4_fb_r;
    end else begin
      fc = e4_fa_r;
      fd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      e4_v_r <= 1'b0;
      e5_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= sq_v;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      e4_v_r <= e3_v_r;
      e5_v_r <= e4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_k_r  <= sq_so.p.k;
      e1_wc_r <= sq_so.p.wc;
      e1_wd_r <= sq_so.p.wd;
      e1_g_r  <= sq_so.g;
      e1_c_r  <= sq_c;
      e1_va_r <= sq_so.p.k.mode ? 34'(vcm) : 34'(sq_so.p.k.vc);
      e1_vb_r <= 34'(sq_so.p.k.vd) - 34'(sq_so.p.k.vc);

      e2_mode_r  <= e1_k_r.mode;
      e2_wc_r    <= e1_wc_r;
      e2_wd_r    <= e1_wd_r;
      e2_pc_r[0] <= smul_n(e1_c_r[0], e1_k_r.nc);
      e2_pc_r[1] <= smul_n(e1_c_r[1], e1_k_r.nd);
      e2_pg_r[0] <= smul_v(e1_g_r[0], e1_va_r);
      e2_pg_r[1] <= smul_v(e1_g_r[1], e1_vb_r);

      e3_mode_r <= e2_mode_r;
      e3_wc_r   <= e2_wc_r;
      e3_wd_r   <= e2_wd_r;
      e3_f_r[0] <= e2_pc_r[0] - e2_pg_r[0];
      e3_f_r[1] <= e2_pc_r[1] - e2_pg_r[1];

      e4_mode_r <= e3_mode_r;
      e4_wa_r   <= wmul(e3_wc_r, e3_f_r[0]);
      e4_wb_r   <= wmul(e3_wd_r, e3_f_r[0]);
      e4_fa_r   <= e3_f_r[0];
      e4_fb_r   <= e3_f_r[1];

      e5_d_r.core_force_add  <= sat32(fc);
      e5_d_r.drude_force_add <= sat32(fd);
    end
  end

  // Output register with one skid word behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || leaving;
      skid_v_r <= 1'b0;
    end else if (leaving) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : e5_d_r;
    end else if (leaving) begin
      skid_d_r <= e5_d_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  a_skid_refills: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ready && skid_v_r) |=> (out_v_r && !skid_v_r))
    else $error("skid word not moved to the output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_d_r)))
    else $error("stalled output word lost or changed");

endmodule
`default_nettype wire

// ===== tb/tb_langevin_drude_pair_force.sv =====
// Testbench for langevin_drude_pair_force: random and directed words are predicted
// in fixed point and checked field by field. Depends on ldpf_pkg and the block itself.
`default_nettype none
module tb_langevin_drude_pair_force;
  import ldpf_pkg::*;

  localparam int LATENCY = 225;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [63:0] U32_MAX = 64'hFFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_index;
  logic [QW-1:0] cfg_wdata;

  langevin_drude_pair_force dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [QW-1:0] regs [8];
  in_t pending_words[$];
  out_t expected_forces[$];
  int failures = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit cfg_req = 0;
  logic [CFG_W-1:0] cfg_req_index;
  logic [QW-1:0] cfg_req_data;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] sat_u32(logic [63:0] x);
    return x > U32_MAX ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
    if (b == 0) return 32'hFFFF_FFFF;
    return sat_u32({16'd0, a, 16'd0} / {32'd0, b});
  endfunction

  function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return sat_u32(p >> 16);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint scaled_mul(logic [63:0] a, longint b, int sh);
    logic [63:0] mag, p;
    mag = b < 0 ? 64'd0 - 64'(b) : 64'(b);
    p = (a * mag) >> sh;
    return b < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint weight_mul(logic [31:0] w, longint b);
    logic [63:0] mag, p;
    mag = b < 0 ? 64'd0 - 64'(b) : 64'(b);
    p = (mag >> 16) * {32'd0, w} + (((mag & 64'hFFFF) * {32'd0, w}) >> 16);
    return b < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] clamp_s32(longint x);
    if (x > 64'sd2147483647) return S32_MAX;
    if (x < -64'sd2147483648) return S32_MIN;
    return x[31:0];
  endfunction

  // Friction and noise amplitude for one mass, period and temperature.
  function automatic void damping_terms(logic [31:0] m, logic [31:0] period,
                                        logic [31:0] temp, output logic [31:0] g,
                                        output logic [31:0] c);
    logic [31:0] x;
    g = q_div(q_div(m, period), regs[CFG_FORCE_ACCEL]);
    x = sat_u32({32'd0, g} * 2);
    x = q_mul(x, regs[CFG_BOLTZMANN]);
    x = q_mul(x, temp);
    x = q_div(x, regs[CFG_TIME_STEP]);
    x = q_div(x, regs[CFG_FORCE_ACCEL]);
    x = q_div(x, regs[CFG_MV2_ENERGY]);
    c = 32'(root64({16'd0, x, 16'd0}));
  endfunction

  function automatic longint thermostat_force(logic [31:0] g, logic [31:0] c,
                                               longint noise, longint v);
    return scaled_mul({32'd0, c}, noise, 12) - scaled_mul({32'd0, g}, v, 16);
  endfunction

  function automatic out_t predict_forces(in_t w);
    out_t r;
    logic [31:0] gc, cc, gd, cd, mu, wc, wd;
    logic [63:0] mt;
    longint vc, vd, nc, nd, fc, fd, vcm, fcm, frel;
    vc = longint'(w.core_velocity);
    vd = longint'(w.drude_velocity);
    nc = longint'(w.core_noise);
    nd = longint'(w.drude_noise);
    if (!w.mode) begin
      damping_terms(w.core_mass, regs[CFG_CORE_PERIOD], regs[CFG_CORE_TEMP], gc, cc);
      fc = thermostat_force(gc, cc, nc, vc);
      fd = 0;
    end else begin
      mt = {32'd0, w.core_mass} + {32'd0, w.drude_mass};
      mu = 0;
      wc = 0;
      wd = 0;
      if (mt != 0) begin
        mu = 32'(({32'd0, w.core_mass} * {32'd0, w.drude_mass}) / mt);
        wc = 32'({16'd0, w.core_mass, 16'd0} / mt);
        wd = 32'({16'd0, w.drude_mass, 16'd0} / mt);
      end
      damping_terms(sat_u32(mt), regs[CFG_CORE_PERIOD], regs[CFG_CORE_TEMP], gc, cc);
      damping_terms(mu, regs[CFG_DRUDE_PERIOD], regs[CFG_DRUDE_TEMP], gd, cd);
      vcm = weight_mul(wc, vc) + weight_mul(wd, vd);
      fcm = thermostat_force(gc, cc, nc, vcm);
      frel = thermostat_force(gd, cd, nd, vd - vc);
      fc = weight_mul(wc, fcm) - frel;
      fd = weight_mul(wd, fcm) + frel;
    end
    r.core_force_add = clamp_s32(fc);
    r.drude_force_add = clamp_s32(fd);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 32'h0010_0000);
      3: return $urandom_range(32'h0000_8000, 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_word(bit quiet);
    in_t w;
    w.mode = $urandom_range(0, 1);
    w.core_mass = quiet ? $urandom_range(1, 32'h0040_0000) : rand_q();
    if (w.core_mass == 0) w.core_mass = 1;
    w.drude_mass = quiet ? $urandom_range(0, 32'h0004_0000) : rand_q();
    w.core_velocity = quiet ? $urandom_range(0, 32'h0020_0000) - 32'h0010_0000 : $urandom;
    w.drude_velocity = quiet ? $urandom_range(0, 32'h0020_0000) - 32'h0010_0000 : $urandom;
    w.core_noise = $urandom;
    w.drude_noise = $urandom;
    return w;
  endfunction

  // Driver for the configuration port; requests are only made while idle.
  always @(posedge clk) begin
    if (cfg_req) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_req_index;
      cfg_wdata <= cfg_req_data;
      regs[cfg_req_index] <= cfg_req_data;
      cfg_req <= 1'b0;
    end else begin
      cfg_we <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_forces.push_back(predict_forces(in_data));
      if (in_gap > 0 || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
        in_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          $error("result word with no expectation pending");
          failures++;
        end else begin
          exp_r = expected_forces.pop_front();
          if (out_data.core_force_add !== exp_r.core_force_add) begin
            $error("core_force_add expected %0d actual %0d",
                   exp_r.core_force_add, out_data.core_force_add);
            failures++;
          end
          if (out_data.drude_force_add !== exp_r.drude_force_add) begin
            $error("drude_force_add expected %0d actual %0d",
                   exp_r.drude_force_add, out_data.drude_force_add);
            failures++;
          end
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("langevin_drude_pair_force verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_W-1:0] idx, logic [31:0] val);
    cfg_req_index = idx;
    cfg_req_data = val;
    cfg_req = 1'b1;
    @(posedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid && expected_forces.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic run_random(int count, bit quiet);
    repeat (count) pending_words.push_back(random_word(quiet));
    drain();
  endtask

  initial begin
    in_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    regs[CFG_CORE_PERIOD] = RST_CORE_PERIOD;
    regs[CFG_DRUDE_PERIOD] = RST_DRUDE_PERIOD;
    regs[CFG_CORE_TEMP] = RST_TEMP;
    regs[CFG_DRUDE_TEMP] = RST_TEMP;
    regs[CFG_BOLTZMANN] = RST_UNIT;
    regs[CFG_TIME_STEP] = RST_UNIT;
    regs[CFG_FORCE_ACCEL] = RST_UNIT;
    regs[CFG_MV2_ENERGY] = RST_UNIT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_CORE_TEMP, 32'h0001_2C00);
    write_reg(CFG_DRUDE_TEMP, 32'h0000_4000);
    // Directed words: field extremes, both modes, zero total mass, huge masses.
    w = '0;
    w.core_mass = 1;
    pending_words.push_back(w);
    w.core_mass = 32'hFFFF_FFFF;
    w.core_velocity = 32'h7FFF_FFFF;
    w.core_noise = 16'h7FFF;
    pending_words.push_back(w);
    w.core_velocity = 32'h8000_0000;
    w.core_noise = 16'h8000;
    pending_words.push_back(w);
    w.mode = 1'b1;
    w.core_mass = 0;
    w.drude_mass = 0;
    pending_words.push_back(w);
    w.core_mass = 32'hFFFF_FFFF;
    w.drude_mass = 32'hFFFF_FFFF;
    w.drude_velocity = 32'h7FFF_FFFF;
    w.drude_noise = 16'h7FFF;
    pending_words.push_back(w);
    w.drude_velocity = 32'h8000_0000;
    w.drude_noise = 16'h8000;
    w.core_velocity = 32'h7FFF_FFFF;
    pending_words.push_back(w);
    w.core_mass = 32'h0001_0000;
    w.drude_mass = 0;
    pending_words.push_back(w);
    w.core_mass = 32'h000A_0000;
    w.drude_mass = 32'h0000_6666;
    w.core_velocity = 32'h0001_8000;
    w.drude_velocity = -32'sh0002_0000;
    w.core_noise = 16'h1000;
    w.drude_noise = -16'sh1000;
    pending_words.push_back(w);
    w.mode = 1'b0;
    pending_words.push_back(w);
    repeat (8) pending_words.push_back(random_word(1'b0));
    drain();

    run_random(300, 1'b1);

    write_reg(CFG_CORE_PERIOD, 1);
    write_reg(CFG_DRUDE_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_CORE_TEMP, 32'hFFFF_FFFF);
    write_reg(CFG_DRUDE_TEMP, 0);
    write_reg(CFG_BOLTZMANN, 32'hFFFF_FFFF);
    write_reg(CFG_TIME_STEP, 1);
    write_reg(CFG_FORCE_ACCEL, 1);
    write_reg(CFG_MV2_ENERGY, 32'hFFFF_FFFF);
    run_random(150, 1'b0);

    write_reg(CFG_CORE_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_DRUDE_PERIOD, 1);
    write_reg(CFG_CORE_TEMP, 0);
    write_reg(CFG_DRUDE_TEMP, 32'hFFFF_FFFF);
    write_reg(CFG_BOLTZMANN, 0);
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_FORCE_ACCEL, 32'hFFFF_FFFF);
    write_reg(CFG_MV2_ENERGY, 1);
    run_random(150, 1'b0);

    write_reg(CFG_CORE_PERIOD, $urandom_range(32'h0000_8000, 32'h0080_0000));
    write_reg(CFG_DRUDE_PERIOD, $urandom_range(32'h0000_1000, 32'h0004_0000));
    write_reg(CFG_CORE_TEMP, $urandom);
    write_reg(CFG_DRUDE_TEMP, $urandom_range(0, 32'h0010_0000));
    write_reg(CFG_BOLTZMANN, $urandom_range(1, 32'h0002_0000));
    write_reg(CFG_TIME_STEP, $urandom_range(32'h0000_1000, 32'h0002_0000));
    write_reg(CFG_FORCE_ACCEL, $urandom_range(32'h0000_4000, 32'h0004_0000));
    write_reg(CFG_MV2_ENERGY, $urandom_range(32'h0000_4000, 32'h0004_0000));
    run_random(280, 1'b1);

    if (failures == 0) begin
      $display("langevin_drude_pair_force verification clean");
    end else begin
      $display("langevin_drude_pair_force verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
